/* rtl/json_nesting_balance_checker_top_defines.svh */
// Assertion macros for the JSON nesting balance checker
`ifndef JSON_NESTING_BALANCE_CHECKER_TOP_DEFINES_SVH
`define JSON_NESTING_BALANCE_CHECKER_TOP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define JNBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jnbc assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define JNBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jnbc assertion failed");

`endif

/* rtl/jnbc_pkg.sv */
// Shared constants for the JSON nesting balance checker
package jnbc_pkg;

    localparam int unsigned MAX_DEPTH = 255;
    localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned M_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

    typedef logic [DEPTH_W-1:0] depth_t;

endpackage

/* rtl/json_nesting_balance_checker_top.sv */
// A last byte passes the input register and the state update; its verdict is then
// held in the verdict register on m_tvalid/m_tdata. Throughput: one byte per cycle
// unless a held verdict stalls a following last byte; other bytes keep flowing.
// Reset: aresetn synchronous, active low; clears the text state and both valid flags.
// Each text produces exactly one verdict transaction, on its last byte.
`include "json_nesting_balance_checker_top_defines.svh"

module json_nesting_balance_checker_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [jnbc_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                           s_tlast,   // is_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [jnbc_pkg::M_DATA_W-1:0]  m_tdata    // [0] balanced, [7:1] zero
);
    import jnbc_pkg::*;

    localparam depth_t DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // text state
    logic   at_start_reg,  at_start_next;
    depth_t brace_depth_reg, brace_depth_next;
    depth_t bracket_depth_reg, bracket_depth_next;
    logic   in_quoted_reg, in_quoted_next;
    logic   escape_reg,    escape_next;
    logic   root_done_reg, root_done_next;
    logic   failed_reg,    failed_next;

    // verdict register
    logic   m_valid_reg;
    logic   balanced_reg;

    logic   proc_fire;
    logic   text_end;
    logic   verdict;
    logic   go;
    logic   is_ws;

    assign proc_fire = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign text_end  = proc_fire && in_last_reg;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_DATA_W-1){1'b0}}, balanced_reg};

    assign is_ws = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_TAB) ||
                   (in_byte_reg == CH_CR)    || (in_byte_reg == CH_LF);

    always_comb begin
        at_start_next      = at_start_reg;
        brace_depth_next   = brace_depth_reg;
        bracket_depth_next = bracket_depth_reg;
        in_quoted_next     = in_quoted_reg;
        escape_next        = escape_reg;
        root_done_next     = root_done_reg;
        failed_next        = failed_reg;
        go                 = 1'b1;

        if (at_start_reg) begin
            at_start_next = 1'b0;
            if (in_byte_reg != CH_LBRACE) begin
                failed_next = 1'b1;
                go          = 1'b0;
            end
        end
        if (go && failed_reg) begin
            go = 1'b0;
        end
        // after the root closes only whitespace may follow
        if (go && root_done_reg) begin
            if (!is_ws) begin
                failed_next = 1'b1;
            end
            go = 1'b0;
        end
        if (go && in_quoted_reg) begin
            if (escape_reg) begin
                escape_next = 1'b0;
            end else if (in_byte_reg == CH_BSLASH) begin
                escape_next = 1'b1;
            end else if (in_byte_reg == CH_QUOTE) begin
                in_quoted_next = 1'b0;
            end
            go = 1'b0;
        end
        if (go && (in_byte_reg == CH_QUOTE)) begin
            in_quoted_next = 1'b1;
            go             = 1'b0;
        end
        if (go) begin
            case (in_byte_reg)
                CH_LBRACE: begin
                    if (brace_depth_reg >= DEPTH_MAX) begin
                        failed_next = 1'b1;
                        go          = 1'b0;
                    end else begin
                        brace_depth_next = brace_depth_reg + 1'b1;
                    end
                end
                CH_RBRACE: begin
                    if (brace_depth_reg == '0) begin
                        failed_next = 1'b1;
                        go          = 1'b0;
                    end else begin
                        brace_depth_next = brace_depth_reg - 1'b1;
                    end
                end
                CH_LBRACK: begin
                    if (bracket_depth_reg >= DEPTH_MAX) begin
                        failed_next = 1'b1;
                        go          = 1'b0;
                    end else begin
                        bracket_depth_next = bracket_depth_reg + 1'b1;
                    end
                end
                CH_RBRACK: begin
                    if (bracket_depth_reg == '0) begin
                        failed_next = 1'b1;
                        go          = 1'b0;
                    end else begin
                        bracket_depth_next = bracket_depth_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (go && (brace_depth_next == '0)) begin
                root_done_next = 1'b1;
            end
        end

        verdict = !failed_next && root_done_next && !in_quoted_next && !escape_next &&
                  (brace_depth_next == '0) && (bracket_depth_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (proc_fire && in_last_reg)) begin
            at_start_reg      <= 1'b1;
            brace_depth_reg   <= '0;
            bracket_depth_reg <= '0;
            in_quoted_reg     <= 1'b0;
            escape_reg        <= 1'b0;
            root_done_reg     <= 1'b0;
            failed_reg        <= 1'b0;
        end else if (proc_fire) begin
            at_start_reg      <= at_start_next;
            brace_depth_reg   <= brace_depth_next;
            bracket_depth_reg <= bracket_depth_next;
            in_quoted_reg     <= in_quoted_next;
            escape_reg        <= escape_next;
            root_done_reg     <= root_done_next;
            failed_reg        <= failed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (proc_fire && in_last_reg) begin
            balanced_reg <= verdict;
        end
    end

    `JNBC_ASSERT_NOW(a_brace_depth_limit, 1'b1, brace_depth_reg <= DEPTH_MAX)
    `JNBC_ASSERT_NOW(a_bracket_depth_limit, 1'b1, bracket_depth_reg <= DEPTH_MAX)
    `JNBC_ASSERT_NOW(a_escape_in_string, escape_reg, in_quoted_reg)
    `JNBC_ASSERT_NOW(a_root_closed_depth, root_done_reg, brace_depth_reg == '0)
    `JNBC_ASSERT_NEXT(a_text_restart, text_end, at_start_reg && !failed_reg && m_valid_reg)
    `JNBC_ASSERT_NEXT(a_failed_verdict, text_end && failed_reg, m_tvalid && !m_tdata[0])

endmodule

/* test/tb.sv */
// Testbench for the JSON nesting balance checker: directed and random texts, scoreboarded verdicts
`timescale 1ns / 100ps

module tb;
    import jnbc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 500;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;   // [7:0] text_byte
    logic                  s_tlast  = 1'b0; // is_last
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // [0] balanced, [7:1] zero

    json_nesting_balance_checker_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Text scanner state, mirrors the block
    typedef struct {
        logic   at_start;
        depth_t brace_d;
        depth_t brack_d;
        logic   in_str;
        logic   esc;
        logic   root_closed;
        logic   failed;
    } doc_scan_t;

    doc_scan_t           doc_scan;
    logic [M_DATA_W-1:0] verdict_q[$];
    logic [M_DATA_W-1:0] exp_verdict;
    logic [7:0]          text_q[$];
    int                  errors      = 0;
    int                  cycles      = 0;
    int                  burst_left  = 0;
    logic                gaps_on     = 1'b1;
    int                  hold_reqs   = 0;
    int                  hold_seen   = 0;
    int                  hold_left   = 0;
    logic [5:0]          rx_phase    = '0;
    logic [1:0]          rx_mode     = '0;

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic void scan_reset();
        doc_scan.at_start    = 1'b1;
        doc_scan.brace_d     = '0;
        doc_scan.brack_d     = '0;
        doc_scan.in_str      = 1'b0;
        doc_scan.esc         = 1'b0;
        doc_scan.root_closed = 1'b0;
        doc_scan.failed      = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        if (doc_scan.at_start) begin
            doc_scan.at_start = 1'b0;
            if (c != CH_LBRACE)
                doc_scan.failed = 1'b1;
        end
        if (doc_scan.failed) begin
            // text already lost, nothing moves
        end else if (doc_scan.root_closed) begin
            if (!is_ws(c))
                doc_scan.failed = 1'b1;
        end else if (doc_scan.in_str) begin
            if (doc_scan.esc)
                doc_scan.esc = 1'b0;
            else if (c == CH_BSLASH)
                doc_scan.esc = 1'b1;
            else if (c == CH_QUOTE)
                doc_scan.in_str = 1'b0;
        end else if (c == CH_QUOTE) begin
            doc_scan.in_str = 1'b1;
        end else begin
            if (c == CH_LBRACE) begin
                if (doc_scan.brace_d >= MAX_DEPTH)
                    doc_scan.failed = 1'b1;
                else
                    doc_scan.brace_d = doc_scan.brace_d + 1'b1;
            end else if (c == CH_RBRACE) begin
                if (doc_scan.brace_d == 0)
                    doc_scan.failed = 1'b1;
                else
                    doc_scan.brace_d = doc_scan.brace_d - 1'b1;
            end else if (c == CH_LBRACK) begin
                if (doc_scan.brack_d >= MAX_DEPTH)
                    doc_scan.failed = 1'b1;
                else
                    doc_scan.brack_d = doc_scan.brack_d + 1'b1;
            end else if (c == CH_RBRACK) begin
                if (doc_scan.brack_d == 0)
                    doc_scan.failed = 1'b1;
                else
                    doc_scan.brack_d = doc_scan.brack_d - 1'b1;
            end
            // failed was clear on entry, so only a fresh failure skips this
            if (!doc_scan.failed && doc_scan.brace_d == 0)
                doc_scan.root_closed = 1'b1;
        end
    endfunction

    function automatic logic scan_verdict();
        return !doc_scan.failed && doc_scan.root_closed && !doc_scan.in_str &&
               !doc_scan.esc && doc_scan.brace_d == 0 && doc_scan.brack_d == 0;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at cycle %0d: %s, got %h expected %h", cycles, what, got, want);
        errors++;
    endtask

    // Sender: one byte per call, bursts separated by random gaps.
    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        scan_byte(c);
        if (last) begin
            verdict_q.push_back({7'b0, scan_verdict()});
            scan_reset();
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_rep(input logic [7:0] c, input int n);
        repeat (n) text_q.push_back(c);
    endtask

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] rand_special();
        case ($urandom_range(0, 5))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_LBRACK;
            3:       return CH_RBRACK;
            4:       return CH_QUOTE;
            default: return CH_BSLASH;
        endcase
    endfunction

    // quoted string with random content; quotes and backslashes are escaped
    task automatic add_quoted();
        logic [7:0] c;
        text_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 7) == 0)
                text_q.push_back(CH_BSLASH);
            text_q.push_back(c);
        end
        text_q.push_back(CH_QUOTE);
    endtask

    // well-formed document with random content, nesting kept in order
    task automatic gen_doc();
        logic [7:0] closers[$];
        logic [7:0] c;
        text_q.delete();
        text_q.push_back(CH_LBRACE);
        closers.push_back(CH_RBRACE);
        while (closers.size() != 0) begin
            if (text_q.size() > 30) begin
                c = closers.pop_back();
                text_q.push_back(c);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        if (closers.size() < 8) begin
                            if ($urandom_range(0, 1)) begin
                                text_q.push_back(CH_LBRACE);
                                closers.push_back(CH_RBRACE);
                            end else begin
                                text_q.push_back(CH_LBRACK);
                                closers.push_back(CH_RBRACK);
                            end
                        end
                    end
                    2, 3: begin
                        c = closers.pop_back();
                        text_q.push_back(c);
                    end
                    4, 5: add_quoted();
                    6:    text_q.push_back(rand_ws());
                    default: begin
                        repeat ($urandom_range(1, 4)) begin
                            c = 8'($urandom_range(1, 255));
                            if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK ||
                                c == CH_RBRACK || c == CH_QUOTE || c == CH_BSLASH)
                                c = ",";
                            text_q.push_back(c);
                        end
                    end
                endcase
            end
        end
        repeat ($urandom_range(0, 2)) text_q.push_back(rand_ws());
    endtask

    // occasionally break a well-formed document
    task automatic mutate_doc();
        int k;
        case ($urandom_range(0, 11))
            0: begin
                k = $urandom_range(0, text_q.size() - 1);
                text_q[k] = 8'($urandom_range(1, 255));
            end
            1: begin
                k = $urandom_range(1, text_q.size());
                while (text_q.size() > k) void'(text_q.pop_back());
            end
            2: text_q.push_back(8'($urandom_range(1, 255)));
            3: begin
                k = $urandom_range(0, text_q.size() - 1);
                text_q[k] = rand_special();
            end
            default: ;
        endcase
    endtask

    task automatic gen_noise();
        text_q.delete();
        repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 1))
                text_q.push_back(rand_special());
            else
                text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic test_well_formed();
        add_str("{}");
        send_text();
        add_str("{ \"a\" : [1, {\"b\":\"x\\\"}\"}], \"c\":[[]] }");
        send_text();
        add_str("{}");
        text_q.push_back(CH_SPACE);
        text_q.push_back(CH_TAB);
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
        send_text();
        // order of braces against brackets is not checked
        add_str("{[}]");
        send_text();
    endtask

    task automatic test_bad_start();
        add_str("x{}");
        send_text();
        add_str(" {}");
        send_text();
        add_str("{");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
    endtask

    task automatic test_underflow();
        add_str("{]}");
        send_text();
        add_str("{[]]}   ");
        send_text();
        add_str("{}");
        send_text();
    endtask

    task automatic test_strings();
        add_str("{\"\\\\\"}");
        send_text();
        add_str("{\"abc");
        send_text();
        add_str("{\"ab\\");
        send_text();
        add_str("{\"}]{[\\\"\"}");
        send_text();
        text_q.push_back(CH_LBRACE);
        text_q.push_back(CH_QUOTE);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        text_q.push_back(CH_QUOTE);
        text_q.push_back(CH_RBRACE);
        send_text();
        // a zero byte carries no meaning
        text_q.push_back(CH_LBRACE);
        text_q.push_back(8'h00);
        text_q.push_back(CH_RBRACE);
        send_text();
    endtask

    task automatic test_trailing();
        add_str("{}x");
        send_text();
        add_str("{} }");
        send_text();
        add_str("{}\n\t \"");
        send_text();
    endtask

    task automatic test_depth_limit();
        // both depths at the limit in one text
        add_rep(CH_LBRACE, MAX_DEPTH);
        add_rep(CH_LBRACK, MAX_DEPTH);
        add_rep(CH_RBRACK, MAX_DEPTH);
        add_rep(CH_RBRACE, MAX_DEPTH);
        send_text();
        add_rep(CH_LBRACE, MAX_DEPTH + 1);
        add_rep(CH_RBRACE, MAX_DEPTH + 1);
        send_text();
        text_q.push_back(CH_LBRACE);
        add_rep(CH_LBRACK, MAX_DEPTH + 1);
        add_rep(CH_RBRACK, MAX_DEPTH + 1);
        text_q.push_back(CH_RBRACE);
        send_text();
    endtask

    // receiver holds off while short texts keep coming, so the block backs up
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_reqs++;
        repeat (30) begin
            add_str("{}");
            send_text();
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 11) == 0) begin
                gen_noise();
            end else begin
                gen_doc();
                mutate_doc();
            end
            sent += text_q.size();
            send_text();
        end
    endtask

    // receiver: stall pattern picked anew each time the 6-bit phase counter wraps, plus the long hold-off
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1'b1;
            if (rx_phase == 0)
                rx_mode <= 2'($urandom_range(0, 3));
            case (rx_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_phase[3];
            endcase
        end
    end

    // verdict checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with none pending", m_tdata, 8'h00);
            end else begin
                exp_verdict = verdict_q.pop_front();
                if (m_tdata !== exp_verdict)
                    report_mismatch("balanced verdict", m_tdata, exp_verdict);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        scan_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_well_formed();
        test_bad_start();
        test_underflow();
        test_strings();
        test_trailing();
        test_depth_limit();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
